// File: sv/vrt_pkg.sv
`timescale 1ns / 1ps
package vrt_pkg;

   localparam int COORD_WIDTH_DEF     = 32;
   localparam int ROTATION_STAGES_DEF = 24;

   // angle is Q4.28 radians
   localparam int ANGLE_WIDTH     = 32;
   localparam int GUARD_BITS      = 8;
   // extra integer bits for CORDIC growth (gain ~1.65, quadrant swap, rounding)
   localparam int CORDIC_HEADROOM = 3;

   localparam longint ANGLE_PI      = 843314857;
   localparam longint ANGLE_HALF_PI = 421657428;
   localparam longint ANGLE_TWO_PI  = 1686629713;

   // limit CORDIC gain 0.60725... scaled by 2^32
   localparam logic [31:0] GAIN_K = 32'd2608131496;

   localparam int ATAN_TABLE_DEPTH = 10;
   localparam logic signed [ANGLE_WIDTH-1:0] ATAN_FIRST [0:ATAN_TABLE_DEPTH-1] = '{
      32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290, 32'sd16755422,
      32'sd8385879,   32'sd4193963,   32'sd2097109,  32'sd1048571,  32'sd524287
   };

   // atan(2^-idx) in Q4.28; beyond the table it is 2^(28-idx), then zero
   function automatic logic signed [ANGLE_WIDTH-1:0] atan_step(input logic [31:0] idx);
      logic signed [ANGLE_WIDTH-1:0] r;
      if (idx < 32'(ATAN_TABLE_DEPTH)) begin
         r = ATAN_FIRST[idx[3:0]];
      end else if (idx <= 32'd28) begin
         r = 32'sd1 <<< (32'd28 - idx);
      end else begin
         r = '0;
      end
      return r;
   endfunction

endpackage

// File: sv/vrt_front_cell.sv
`timescale 1ns / 1ps
module vrt_front_cell #(
   parameter int COORD_WIDTH = vrt_pkg::COORD_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  up_valid,
   output logic                                  up_ready,
   input  logic signed [COORD_WIDTH-1:0]         vec_x,
   input  logic signed [COORD_WIDTH-1:0]         vec_y,
   input  logic signed [vrt_pkg::ANGLE_WIDTH-1:0] angle,
   input  logic signed [COORD_WIDTH-1:0]         trans_x,
   input  logic signed [COORD_WIDTH-1:0]         trans_y,
   output logic                                  dn_valid,
   input  logic                                  dn_ready,
   output logic signed [COORD_WIDTH:0]           x,
   output logic signed [COORD_WIDTH:0]           y,
   output logic signed [vrt_pkg::ANGLE_WIDTH-1:0] a,
   output logic signed [COORD_WIDTH-1:0]         tx,
   output logic signed [COORD_WIDTH-1:0]         ty
);
   import vrt_pkg::*;

   localparam int QW = COORD_WIDTH + 1;
   localparam int RW = ANGLE_WIDTH + 2;

   localparam logic signed [RW-1:0] PI_W       = RW'(ANGLE_PI);
   localparam logic signed [RW-1:0] NEG_PI_W   = -RW'(ANGLE_PI);
   localparam logic signed [RW-1:0] TWO_PI_W   = RW'(ANGLE_TWO_PI);
   localparam logic signed [RW-1:0] HALF_PI_W  = RW'(ANGLE_HALF_PI);
   localparam logic signed [RW-1:0] NEG_HALF_W = -RW'(ANGLE_HALF_PI);

   logic                          valid_ff, valid_in;
   logic signed [QW-1:0]          x_ff, x_in, y_ff, y_in;
   logic signed [ANGLE_WIDTH-1:0] a_ff, a_in;
   logic signed [COORD_WIDTH-1:0] tx_ff, ty_ff;
   logic signed [RW-1:0]          a_wide, a_red, a_quad;
   logic signed [QW-1:0]          x_ext, y_ext;
   logic                          load;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      a_wide = {{2{angle[ANGLE_WIDTH-1]}}, angle};
      x_ext  = {vec_x[COORD_WIDTH-1], vec_x};
      y_ext  = {vec_y[COORD_WIDTH-1], vec_y};

      // wrap once into [-pi, pi]
      if (a_wide > PI_W) begin
         a_red = a_wide - TWO_PI_W;
      end else if (a_wide < NEG_PI_W) begin
         a_red = a_wide + TWO_PI_W;
      end else begin
         a_red = a_wide;
      end

      // fold outer quadrants by a quarter turn
      if (a_red > HALF_PI_W) begin
         x_in   = -y_ext;
         y_in   = x_ext;
         a_quad = a_red - HALF_PI_W;
      end else if (a_red < NEG_HALF_W) begin
         x_in   = y_ext;
         y_in   = -x_ext;
         a_quad = a_red + HALF_PI_W;
      end else begin
         x_in   = x_ext;
         y_in   = y_ext;
         a_quad = a_red;
      end
      a_in = a_quad[ANGLE_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         a_ff  <= a_in;
         tx_ff <= trans_x;
         ty_ff <= trans_y;
      end
   end

   assign dn_valid = valid_ff;
   assign x        = x_ff;
   assign y        = y_ff;
   assign a        = a_ff;
   assign tx       = tx_ff;
   assign ty       = ty_ff;

endmodule

// File: sv/vrt_gain_cell.sv
`timescale 1ns / 1ps
module vrt_gain_cell #(
   parameter int COORD_WIDTH = vrt_pkg::COORD_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  up_valid,
   output logic                                  up_ready,
   input  logic signed [COORD_WIDTH:0]           x,
   input  logic signed [COORD_WIDTH:0]           y,
   input  logic signed [vrt_pkg::ANGLE_WIDTH-1:0] a,
   input  logic signed [COORD_WIDTH-1:0]         tx,
   input  logic signed [COORD_WIDTH-1:0]         ty,
   output logic                                  dn_valid,
   input  logic                                  dn_ready,
   output logic signed [COORD_WIDTH+vrt_pkg::GUARD_BITS+vrt_pkg::CORDIC_HEADROOM-1:0] x_out,
   output logic signed [COORD_WIDTH+vrt_pkg::GUARD_BITS+vrt_pkg::CORDIC_HEADROOM-1:0] y_out,
   output logic signed [vrt_pkg::ANGLE_WIDTH-1:0] a_out,
   output logic signed [COORD_WIDTH-1:0]         tx_out,
   output logic signed [COORD_WIDTH-1:0]         ty_out
);
   import vrt_pkg::*;

   localparam int QW   = COORD_WIDTH + 1;
   localparam int CW   = COORD_WIDTH + GUARD_BITS + CORDIC_HEADROOM;
   localparam int HW   = (QW > 32) ? QW - 32 : 1;
   localparam int UW   = HW + 32;
   localparam int PHW  = HW + 32;
   localparam int LSW  = 65;
   localparam int SUMW = PHW + GUARD_BITS + 1;
   localparam logic [LSW-1:0] GAIN_RND = LSW'(1) << (31 - GUARD_BITS);

   // stage one: magnitude times K as two partial products
   logic                          v1_ff, v1_in, rdy1, load1;
   logic                          negx_ff, negy_ff;
   logic [63:0]                   plx_ff, plx_in, ply_ff, ply_in;
   logic [PHW-1:0]                phx_ff, phx_in, phy_ff, phy_in;
   logic signed [ANGLE_WIDTH-1:0] a1_ff;
   logic signed [COORD_WIDTH-1:0] tx1_ff, ty1_ff;
   logic [QW-1:0]                 ux, uy;
   logic [UW-1:0]                 ux_ext, uy_ext;

   // stage two: combine, round, restore sign
   logic                          v2_ff, v2_in, rdy2, load2;
   logic [LSW-1:0]                lsx, lsy;
   logic [SUMW-1:0]               sumx, sumy;
   logic signed [CW-1:0]          magx, magy, x2_ff, x2_in, y2_ff, y2_in;
   logic signed [ANGLE_WIDTH-1:0] a2_ff;
   logic signed [COORD_WIDTH-1:0] tx2_ff, ty2_ff;

   assign rdy2     = !v2_ff || dn_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign up_ready = rdy1;
   assign load1    = up_valid && rdy1;
   assign load2    = v1_ff && rdy2;
   assign v1_in    = rdy1 ? up_valid : v1_ff;
   assign v2_in    = rdy2 ? v1_ff : v2_ff;

   always_comb begin
      ux     = x[QW-1] ? QW'(-x) : QW'(x);
      uy     = y[QW-1] ? QW'(-y) : QW'(y);
      ux_ext = UW'(ux);
      uy_ext = UW'(uy);
      plx_in = 64'(ux_ext[31:0]) * 64'(GAIN_K);
      ply_in = 64'(uy_ext[31:0]) * 64'(GAIN_K);
      phx_in = PHW'(ux_ext[UW-1:32]) * PHW'(GAIN_K);
      phy_in = PHW'(uy_ext[UW-1:32]) * PHW'(GAIN_K);
   end

   always_comb begin
      lsx   = {1'b0, plx_ff} + GAIN_RND;
      lsy   = {1'b0, ply_ff} + GAIN_RND;
      sumx  = SUMW'({phx_ff, {GUARD_BITS{1'b0}}}) + SUMW'(lsx[LSW-1:32-GUARD_BITS]);
      sumy  = SUMW'({phy_ff, {GUARD_BITS{1'b0}}}) + SUMW'(lsy[LSW-1:32-GUARD_BITS]);
      magx  = CW'(sumx);
      magy  = CW'(sumy);
      x2_in = negx_ff ? -magx : magx;
      y2_in = negy_ff ? -magy : magy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         negx_ff <= x[QW-1];
         negy_ff <= y[QW-1];
         plx_ff  <= plx_in;
         ply_ff  <= ply_in;
         phx_ff  <= phx_in;
         phy_ff  <= phy_in;
         a1_ff   <= a;
         tx1_ff  <= tx;
         ty1_ff  <= ty;
      end
      if (load2) begin
         x2_ff  <= x2_in;
         y2_ff  <= y2_in;
         a2_ff  <= a1_ff;
         tx2_ff <= tx1_ff;
         ty2_ff <= ty1_ff;
      end
   end

   assign dn_valid = v2_ff;
   assign x_out    = x2_ff;
   assign y_out    = y2_ff;
   assign a_out    = a2_ff;
   assign tx_out   = tx2_ff;
   assign ty_out   = ty2_ff;

endmodule

// File: sv/vrt_rotate_cell.sv
`timescale 1ns / 1ps
module vrt_rotate_cell #(
   parameter int COORD_WIDTH = vrt_pkg::COORD_WIDTH_DEF,
   parameter int STAGE       = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  up_valid,
   output logic                                  up_ready,
   input  logic signed [COORD_WIDTH+vrt_pkg::GUARD_BITS+vrt_pkg::CORDIC_HEADROOM-1:0] x,
   input  logic signed [COORD_WIDTH+vrt_pkg::GUARD_BITS+vrt_pkg::CORDIC_HEADROOM-1:0] y,
   input  logic signed [vrt_pkg::ANGLE_WIDTH-1:0] a,
   input  logic signed [COORD_WIDTH-1:0]         tx,
   input  logic signed [COORD_WIDTH-1:0]         ty,
   output logic                                  dn_valid,
   input  logic                                  dn_ready,
   output logic signed [COORD_WIDTH+vrt_pkg::GUARD_BITS+vrt_pkg::CORDIC_HEADROOM-1:0] x_out,
   output logic signed [COORD_WIDTH+vrt_pkg::GUARD_BITS+vrt_pkg::CORDIC_HEADROOM-1:0] y_out,
   output logic signed [vrt_pkg::ANGLE_WIDTH-1:0] a_out,
   output logic signed [COORD_WIDTH-1:0]         tx_out,
   output logic signed [COORD_WIDTH-1:0]         ty_out
);
   import vrt_pkg::*;

   localparam int CW = COORD_WIDTH + GUARD_BITS + CORDIC_HEADROOM;
   localparam logic signed [ANGLE_WIDTH-1:0] ATAN_I = atan_step(32'(STAGE));

   logic                          valid_ff, valid_in, load;
   logic signed [CW-1:0]          dx, dy, x_ff, x_in, y_ff, y_in;
   logic signed [ANGLE_WIDTH-1:0] a_ff, a_in;
   logic signed [COORD_WIDTH-1:0] tx_ff, ty_ff;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      dx = x >>> STAGE;
      dy = y >>> STAGE;
      // turn toward a zero residual angle
      if (!a[ANGLE_WIDTH-1]) begin
         x_in = x - dy;
         y_in = y + dx;
         a_in = a - ATAN_I;
      end else begin
         x_in = x + dy;
         y_in = y - dx;
         a_in = a + ATAN_I;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         a_ff  <= a_in;
         tx_ff <= tx;
         ty_ff <= ty;
      end
   end

   assign dn_valid = valid_ff;
   assign x_out    = x_ff;
   assign y_out    = y_ff;
   assign a_out    = a_ff;
   assign tx_out   = tx_ff;
   assign ty_out   = ty_ff;

endmodule

// File: sv/vrt_back_cell.sv
`timescale 1ns / 1ps
module vrt_back_cell #(
   parameter int COORD_WIDTH = vrt_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  logic signed [COORD_WIDTH+vrt_pkg::GUARD_BITS+vrt_pkg::CORDIC_HEADROOM-1:0] x,
   input  logic signed [COORD_WIDTH+vrt_pkg::GUARD_BITS+vrt_pkg::CORDIC_HEADROOM-1:0] y,
   input  logic signed [COORD_WIDTH-1:0] tx,
   input  logic signed [COORD_WIDTH-1:0] ty,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output logic signed [COORD_WIDTH-1:0] new_x,
   output logic signed [COORD_WIDTH-1:0] new_y,
   output logic                          overflow
);
   import vrt_pkg::*;

   localparam int CW = COORD_WIDTH + GUARD_BITS + CORDIC_HEADROOM;
   localparam int RW = CW - GUARD_BITS;
   localparam int SW = RW + 1;
   localparam logic [CW-1:0] ROUND_HALF =
      {{(CW-GUARD_BITS){1'b0}}, 1'b1, {(GUARD_BITS-1){1'b0}}};
   localparam logic [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic                          valid_ff, valid_in, load;
   logic [CW-1:0]                 rx, ry;
   logic [SW-1:0]                 sx, sy;
   logic                          ovx, ovy;
   logic signed [COORD_WIDTH-1:0] nx_ff, nx_in, ny_ff, ny_in;
   logic                          ovf_ff, ovf_in;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      // drop guard bits, round half up
      rx = x + ROUND_HALF;
      ry = y + ROUND_HALF;
      sx = {rx[CW-1], rx[CW-1:GUARD_BITS]} +
           {{(SW-COORD_WIDTH){tx[COORD_WIDTH-1]}}, tx};
      sy = {ry[CW-1], ry[CW-1:GUARD_BITS]} +
           {{(SW-COORD_WIDTH){ty[COORD_WIDTH-1]}}, ty};
      // out of range when the top bits disagree
      ovx = !(&sx[SW-1:COORD_WIDTH-1]) && (|sx[SW-1:COORD_WIDTH-1]);
      ovy = !(&sy[SW-1:COORD_WIDTH-1]) && (|sy[SW-1:COORD_WIDTH-1]);
      nx_in  = ovx ? (sx[SW-1] ? SAT_MIN : SAT_MAX) : sx[COORD_WIDTH-1:0];
      ny_in  = ovy ? (sy[SW-1] ? SAT_MIN : SAT_MAX) : sy[COORD_WIDTH-1:0];
      ovf_in = ovx || ovy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         nx_ff  <= nx_in;
         ny_ff  <= ny_in;
         ovf_ff <= ovf_in;
      end
   end

   assign dn_valid = valid_ff;
   assign new_x    = nx_ff;
   assign new_y    = ny_ff;
   assign overflow = ovf_ff;

endmodule

// File: sv/vector2d_rotate_translate.sv
`timescale 1ns / 1ps
// Rotate a Q16.16 vector by a Q4.28 radian angle, then add a translation and
// saturate. The angle is wrapped once into [-pi, pi], folded into the right
// half plane by a quarter turn, and the coordinates are pre-scaled by the
// CORDIC gain; then ROTATION_STAGES CORDIC cells of one kind each turn the
// vector by atan(2^-i) and hand it to the next. A final cell rounds off the
// guard bits, adds the offset and clamps, raising overflow when either
// coordinate clamps. Every cell is a register stage, so one beat enters per
// clock unless rsp_stall has backed up the chain, and a beat passes in
// turn through the front cell, the two gain-multiply stages, the rotation
// cells and the output cell. The block holds no state beyond beats in
// flight. Each cell takes a new beat whenever it is empty or its neighbor
// takes its own, so bubbles are squeezed out under stall; req_stall rises
// only when every cell is full and rsp_stall is high.
module vector2d_rotate_translate #(
   parameter int COORD_WIDTH     = vrt_pkg::COORD_WIDTH_DEF,
   parameter int ROTATION_STAGES = vrt_pkg::ROTATION_STAGES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_WIDTH-1:0]         req_vec_x,
   input  logic signed [COORD_WIDTH-1:0]         req_vec_y,
   input  logic signed [vrt_pkg::ANGLE_WIDTH-1:0] req_angle,
   input  logic signed [COORD_WIDTH-1:0]         req_trans_x,
   input  logic signed [COORD_WIDTH-1:0]         req_trans_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [COORD_WIDTH-1:0]         rsp_new_x,
   output logic signed [COORD_WIDTH-1:0]         rsp_new_y,
   output logic                                  rsp_overflow
);
   import vrt_pkg::*;

   localparam int QW = COORD_WIDTH + 1;
   localparam int CW = COORD_WIDTH + GUARD_BITS + CORDIC_HEADROOM;

   // front cell to gain cell
   logic                          fr_valid, fr_ready, fr_up_ready;
   logic signed [QW-1:0]          fr_x, fr_y;
   logic signed [ANGLE_WIDTH-1:0] fr_a;
   logic signed [COORD_WIDTH-1:0] fr_tx, fr_ty;

   // rotation chain, entry i feeds rotation cell i, last entry feeds output cell
   logic                          rot_valid [0:ROTATION_STAGES];
   logic                          rot_ready [0:ROTATION_STAGES];
   logic signed [CW-1:0]          rot_x     [0:ROTATION_STAGES];
   logic signed [CW-1:0]          rot_y     [0:ROTATION_STAGES];
   logic signed [ANGLE_WIDTH-1:0] rot_a     [0:ROTATION_STAGES];
   logic signed [COORD_WIDTH-1:0] rot_tx    [0:ROTATION_STAGES];
   logic signed [COORD_WIDTH-1:0] rot_ty    [0:ROTATION_STAGES];

   assign req_stall = !fr_up_ready;

   vrt_front_cell #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (fr_up_ready),
      .vec_x    (req_vec_x),
      .vec_y    (req_vec_y),
      .angle    (req_angle),
      .trans_x  (req_trans_x),
      .trans_y  (req_trans_y),
      .dn_valid (fr_valid),
      .dn_ready (fr_ready),
      .x        (fr_x),
      .y        (fr_y),
      .a        (fr_a),
      .tx       (fr_tx),
      .ty       (fr_ty)
   );

   vrt_gain_cell #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_gain (
      .clock    (clock),
      .reset    (reset),
      .up_valid (fr_valid),
      .up_ready (fr_ready),
      .x        (fr_x),
      .y        (fr_y),
      .a        (fr_a),
      .tx       (fr_tx),
      .ty       (fr_ty),
      .dn_valid (rot_valid[0]),
      .dn_ready (rot_ready[0]),
      .x_out    (rot_x[0]),
      .y_out    (rot_y[0]),
      .a_out    (rot_a[0]),
      .tx_out   (rot_tx[0]),
      .ty_out   (rot_ty[0])
   );

   // one cell per CORDIC iteration; the residual angle rides along with the beat
   for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_rot
      vrt_rotate_cell #(
         .COORD_WIDTH (COORD_WIDTH),
         .STAGE       (i)
      ) u_rot (
         .clock    (clock),
         .reset    (reset),
         .up_valid (rot_valid[i]),
         .up_ready (rot_ready[i]),
         .x        (rot_x[i]),
         .y        (rot_y[i]),
         .a        (rot_a[i]),
         .tx       (rot_tx[i]),
         .ty       (rot_ty[i]),
         .dn_valid (rot_valid[i+1]),
         .dn_ready (rot_ready[i+1]),
         .x_out    (rot_x[i+1]),
         .y_out    (rot_y[i+1]),
         .a_out    (rot_a[i+1]),
         .tx_out   (rot_tx[i+1]),
         .ty_out   (rot_ty[i+1])
      );
   end

   // the residual angle is spent once the last rotation is done
   vrt_back_cell #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .up_valid (rot_valid[ROTATION_STAGES]),
      .up_ready (rot_ready[ROTATION_STAGES]),
      .x        (rot_x[ROTATION_STAGES]),
      .y        (rot_y[ROTATION_STAGES]),
      .tx       (rot_tx[ROTATION_STAGES]),
      .ty       (rot_ty[ROTATION_STAGES]),
      .dn_valid (rsp_valid),
      .dn_ready (!rsp_stall),
      .new_x    (rsp_new_x),
      .new_y    (rsp_new_y),
      .overflow (rsp_overflow)
   );

endmodule
